/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LZW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LZW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/lzw_vwc_pkg.sv */
// ----------------------------------------------------------------------------
// lzw_vwc_pkg
// Shared types for the LZW compressor controller and datapath.
// ----------------------------------------------------------------------------
package lzw_vwc_pkg;

  localparam int unsigned LitCount   = 256;
  localparam int unsigned StartWidth = 9;

  typedef struct packed {
    logic load_in;
    logic set_prefix_byte;
    logic set_prefix_cur;
    logic rd_fc;
    logic cap_fc;
    logic rd_node;
    logic step_sib;
    logic add1;
    logic add2;
    logic push_full;
    logic load_code;
    logic push_drain;
    logic grow;
    logic push_flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic present;
    logic last;
    logic tot_full;
    logic tot_gt8;
    logic cur_zero;
    logic byte_match;
    logic dict_room;
    logic out_free;
  } status_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_DECODE = 11'b000_0000_0010,
    ST_FC     = 11'b000_0000_0100,
    ST_WALK   = 11'b000_0000_1000,
    ST_NODE   = 11'b000_0001_0000,
    ST_ADD1   = 11'b000_0010_0000,
    ST_ADD2   = 11'b000_0100_0000,
    ST_EFULL  = 11'b000_1000_0000,
    ST_LOAD   = 11'b001_0000_0000,
    ST_DRAIN  = 11'b010_0000_0000,
    ST_FLUSH  = 11'b100_0000_0000
  } state_e;

endpackage

/* src/lzw_vwc_ctrl.sv */
// ----------------------------------------------------------------------------
// lzw_vwc_ctrl
// Sequencer: dictionary lookup walk, insert, code emission and flush.
// ----------------------------------------------------------------------------
module lzw_vwc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lzw_vwc_pkg::status_t  sts_i,
  output lzw_vwc_pkg::cmd_t     cmd_o
);

  lzw_vwc_pkg::state_e state_q, state_d;
  logic                final_q, final_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzw_vwc_pkg::ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  assign in_stall_o = (state_q != lzw_vwc_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cmd_o   = '0;
    case (state_q)
      lzw_vwc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = lzw_vwc_pkg::ST_DECODE;
        end
      end
      lzw_vwc_pkg::ST_DECODE: begin
        if (!sts_i.present) begin
          cmd_o.set_prefix_byte = 1'b1;
          if (sts_i.last) begin
            final_d = 1'b1;
            state_d = lzw_vwc_pkg::ST_EFULL;
          end else begin
            state_d = lzw_vwc_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.rd_fc = 1'b1;
          state_d     = lzw_vwc_pkg::ST_FC;
        end
      end
      lzw_vwc_pkg::ST_FC: begin
        cmd_o.cap_fc = 1'b1;
        state_d      = lzw_vwc_pkg::ST_WALK;
      end
      lzw_vwc_pkg::ST_WALK: begin
        if (sts_i.cur_zero) begin
          final_d = 1'b0;
          state_d = sts_i.dict_room ? lzw_vwc_pkg::ST_ADD1 : lzw_vwc_pkg::ST_EFULL;
        end else begin
          cmd_o.rd_node = 1'b1;
          state_d       = lzw_vwc_pkg::ST_NODE;
        end
      end
      lzw_vwc_pkg::ST_NODE: begin
        if (sts_i.byte_match) begin
          cmd_o.set_prefix_cur = 1'b1;
          if (sts_i.last) begin
            final_d = 1'b1;
            state_d = lzw_vwc_pkg::ST_EFULL;
          end else begin
            state_d = lzw_vwc_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.step_sib = 1'b1;
          state_d        = lzw_vwc_pkg::ST_WALK;
        end
      end
      lzw_vwc_pkg::ST_ADD1: begin
        cmd_o.add1 = 1'b1;
        state_d    = lzw_vwc_pkg::ST_ADD2;
      end
      lzw_vwc_pkg::ST_ADD2: begin
        cmd_o.add2 = 1'b1;
        state_d    = lzw_vwc_pkg::ST_EFULL;
      end
      lzw_vwc_pkg::ST_EFULL: begin
        if (!sts_i.tot_full) begin
          state_d = lzw_vwc_pkg::ST_LOAD;
        end else if (sts_i.out_free) begin
          cmd_o.push_full = 1'b1;
          state_d         = lzw_vwc_pkg::ST_LOAD;
        end
      end
      lzw_vwc_pkg::ST_LOAD: begin
        cmd_o.load_code = 1'b1;
        state_d         = lzw_vwc_pkg::ST_DRAIN;
      end
      lzw_vwc_pkg::ST_DRAIN: begin
        if (sts_i.tot_gt8) begin
          cmd_o.push_drain = sts_i.out_free;
        end else if (final_q) begin
          state_d = lzw_vwc_pkg::ST_FLUSH;
        end else begin
          cmd_o.grow            = 1'b1;
          cmd_o.set_prefix_byte = 1'b1;
          if (sts_i.last) begin
            final_d = 1'b1;
            state_d = lzw_vwc_pkg::ST_EFULL;
          end else begin
            state_d = lzw_vwc_pkg::ST_IDLE;
          end
        end
      end
      lzw_vwc_pkg::ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push_flush = 1'b1;
          cmd_o.clear      = 1'b1;
          final_d          = 1'b0;
          state_d          = lzw_vwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lzw_vwc_pkg::ST_IDLE;
        final_d = 1'b0;
      end
    endcase
  end

endmodule

/* src/lzw_vwc_dp.sv */
// ----------------------------------------------------------------------------
// lzw_vwc_dp
// Dictionary memories, prefix and width state, bit packer and output word.
// ----------------------------------------------------------------------------
module lzw_vwc_dp #(
  parameter int unsigned MAX_CODE_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o,
  input  lzw_vwc_pkg::cmd_t     cmd_i,
  output lzw_vwc_pkg::status_t  sts_o
);

  localparam int unsigned CW    = MAX_CODE_BITS;
  localparam int unsigned Depth = 1 << CW;
  localparam int unsigned NW    = CW + 2;
  localparam int unsigned WB    = $clog2(CW + 2);
  localparam int unsigned AccW  = CW + 8;
  localparam int unsigned TW    = $clog2(AccW + 1);

  logic [CW-1:0]   fc_mem   [Depth];
  logic [CW+7:0]   node_mem [Depth];
  logic [CW-1:0]   fc_rd_q;
  logic [CW+7:0]   node_rd_q;

  logic [lzw_vwc_pkg::LitCount-1:0] lit_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic [CW-1:0]   prefix_q;
  logic            present_q;
  logic [CW-1:0]   head_q;
  logic [CW-1:0]   cur_q;
  logic [CW:0]     nfc_q;
  logic [WB-1:0]   w_q;
  logic [AccW-1:0] acc_q;
  logic [TW-1:0]   tot_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            out_free;
  logic            push;
  logic [7:0]      push_byte;
  logic [AccW-1:0] drain_sh;
  logic [AccW-1:0] flush_sh;
  logic [AccW-1:0] code_mask;
  logic [NW-1:0]   pow_w;
  logic            prefix_lit;
  logic [CW-1:0]   nfc_idx;
  logic [CW-1:0]   fc_wdata;
  logic [CW-1:0]   fc_waddr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign push       = cmd_i.push_full || cmd_i.push_drain || cmd_i.push_flush;
  assign drain_sh   = acc_q >> (tot_q - TW'(8));
  assign flush_sh   = acc_q << (TW'(8) - tot_q);
  assign code_mask  = (AccW'(1) << w_q) - AccW'(1);
  assign pow_w      = NW'(1) << w_q;
  assign prefix_lit = (prefix_q < CW'(lzw_vwc_pkg::LitCount));
  assign nfc_idx    = nfc_q[CW-1:0];

  always_comb begin
    push_byte = acc_q[7:0];
    if (cmd_i.push_drain) begin
      push_byte = drain_sh[7:0];
    end else if (cmd_i.push_flush) begin
      push_byte = flush_sh[7:0];
    end
  end

  always_comb begin
    fc_waddr = nfc_idx;
    fc_wdata = '0;
    if (cmd_i.add1) begin
      fc_waddr = prefix_q;
      fc_wdata = nfc_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add1 || cmd_i.add2) begin
      fc_mem[fc_waddr] <= fc_wdata;
    end
    if (cmd_i.rd_fc) begin
      fc_rd_q <= fc_mem[prefix_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add1) begin
      node_mem[nfc_idx] <= {head_q, byte_q};
    end
    if (cmd_i.rd_node) begin
      node_rd_q <= node_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.set_prefix_byte) begin
      prefix_q <= CW'(byte_q);
    end else if (cmd_i.set_prefix_cur) begin
      prefix_q <= cur_q;
    end
    if (cmd_i.cap_fc) begin
      head_q <= (prefix_lit && !lit_q[prefix_q[7:0]]) ? '0 : fc_rd_q;
      cur_q  <= (prefix_lit && !lit_q[prefix_q[7:0]]) ? '0 : fc_rd_q;
    end else if (cmd_i.step_sib) begin
      cur_q <= node_rd_q[CW+7:8];
    end
    if (cmd_i.load_code) begin
      acc_q <= (acc_q << w_q) | (AccW'(prefix_q) & code_mask);
    end
    if (push) begin
      out_byte_q <= push_byte;
      out_last_q <= cmd_i.push_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q       <= '0;
      present_q   <= 1'b0;
      nfc_q       <= (CW + 1)'(lzw_vwc_pkg::LitCount);
      w_q         <= WB'(lzw_vwc_pkg::StartWidth);
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_prefix_byte) begin
        present_q <= 1'b1;
      end
      if (cmd_i.add1 && prefix_lit) begin
        lit_q[prefix_q[7:0]] <= 1'b1;
      end
      if (cmd_i.add2) begin
        nfc_q <= nfc_q + (CW + 1)'(1);
      end
      if (cmd_i.grow && (NW'(nfc_q) == pow_w)) begin
        w_q <= w_q + WB'(1);
      end
      if (cmd_i.push_full) begin
        tot_q <= '0;
      end else if (cmd_i.load_code) begin
        tot_q <= tot_q + TW'(w_q);
      end else if (cmd_i.push_drain) begin
        tot_q <= tot_q - TW'(8);
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        lit_q     <= '0;
        present_q <= 1'b0;
        nfc_q     <= (CW + 1)'(lzw_vwc_pkg::LitCount);
        w_q       <= WB'(lzw_vwc_pkg::StartWidth);
        tot_q     <= '0;
      end
    end
  end

  assign sts_o.present    = present_q;
  assign sts_o.last       = last_q;
  assign sts_o.tot_full   = (tot_q == TW'(8));
  assign sts_o.tot_gt8    = (tot_q > TW'(8));
  assign sts_o.cur_zero   = (cur_q == '0);
  assign sts_o.byte_match = (node_rd_q[7:0] == byte_q);
  assign sts_o.dict_room  = (nfc_q < (CW + 1)'(Depth));
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

/* src/lzw_variable_width_compressor_top.sv */
// Sequence: the first byte of a stream only becomes the prefix; a later byte reads the first-child
// link and then walks the sibling nodes; a miss inserts a dictionary entry while there is room,
// then emits the prefix code and drains whole bytes from the packer. A final byte adds the
// last code emission and a flush of the remaining packer bits.
// Input: one byte at a time, stalled until the previous byte is processed; output stalls hold emission and flush.
// Reset: asynchronous, active low; dictionary links clear via literal valid bits.
// ----------------------------------------------------------------------------
// lzw_variable_width_compressor_top
// LZW byte compressor with variable code width and MSB-first packing.
// ----------------------------------------------------------------------------
module lzw_variable_width_compressor_top #(
  parameter int unsigned MAX_CODE_BITS = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  lzw_vwc_pkg::cmd_t    cmd;
  lzw_vwc_pkg::status_t sts;

  lzw_vwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzw_vwc_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* src/lzw_vwc_checker.sv */
// ----------------------------------------------------------------------------
// lzw_vwc_checker
// Port-level checks on the compressor top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_vwc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  `LZW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
  `LZW_ASSERT_IMPL(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, ##1 in_stall_o)
  `LZW_ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, out_valid_o && out_last_o && !out_stall_i, !out_valid_o)

endmodule

bind lzw_variable_width_compressor_top lzw_vwc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
